>>> rtl/oip_pkg.sv
// ----------------------------------------------------------------------------
// oip_pkg
// Shared types and constants for the update-invitation datagram parser.
// ----------------------------------------------------------------------------
package oip_pkg;

    // number of hex digits in the digest field
    localparam int DIGEST_HEX_DIGITS = 32;
    localparam int HEX_CNT_W         = 6;

    // queue between the byte classifier and the parser
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // field limits
    localparam logic [31:0] CMD_HUNDRED = 32'd100;
    localparam logic [6:0]  CMD_CODE_HUNDRED = 7'd100;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // parser phase, one-hot
    typedef enum logic [6:0] {
        PH_COMMAND = 7'b0000001,
        PH_PORT    = 7'b0000010,
        PH_SIZE    = 7'b0000100,
        PH_DIGEST  = 7'b0001000,
        PH_DONE    = 7'b0010000,
        PH_CR      = 7'b0100000,
        PH_LF      = 7'b1000000
    } t_phase;

    // classified byte as it travels through the queue
    typedef struct packed {
        logic       is_digit;
        logic       is_hex;
        logic       is_space;
        logic       is_cr;
        logic       is_lf;
        logic [3:0] nibble;
        logic       last;
    } t_cls;

    // one parse result
    typedef struct packed {
        logic        parse_ok;
        logic [6:0]  command_code;
        logic [15:0] port_number;
        logic [31:0] image_bytes;
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } t_result;

endpackage

>>> rtl/oip_front.sv
// ----------------------------------------------------------------------------
// oip_front
// Accepts datagram bytes, classifies each one and holds it in a short queue.
// ----------------------------------------------------------------------------
module oip_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_ready,
    output logic              o_item_valid,
    output oip_pkg::t_cls     o_item,
    input  logic              i_pop
);

    oip_pkg::t_cls                   w_cls;
    oip_pkg::t_cls                   r_mem [oip_pkg::QUEUE_DEPTH];
    logic [oip_pkg::QPTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [oip_pkg::QPTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [oip_pkg::QCNT_W-1:0]      r_count, n_count;
    logic                            w_push;
    logic                            w_pop;
    logic                            w_lower, w_upper;

    // byte classification
    always_comb begin
        w_lower = (i_byte >= oip_pkg::CH_LA) && (i_byte <= oip_pkg::CH_LF_HEX);
        w_upper = (i_byte >= oip_pkg::CH_UA) && (i_byte <= oip_pkg::CH_UF);
        w_cls.is_digit = (i_byte >= oip_pkg::CH_ZERO) && (i_byte <= oip_pkg::CH_NINE);
        w_cls.is_hex   = w_cls.is_digit || w_lower || w_upper;
        w_cls.is_space = (i_byte == oip_pkg::CH_SPACE);
        w_cls.is_cr    = (i_byte == oip_pkg::CH_CR);
        w_cls.is_lf    = (i_byte == oip_pkg::CH_LF);
        // letters a-f and A-F share the low nibble 1..6
        w_cls.nibble   = w_cls.is_digit ? i_byte[3:0] : (i_byte[3:0] + 4'd9);
        w_cls.last     = i_last;
    end

    // queue handshake
    assign o_ready      = (r_count != oip_pkg::QCNT_W'(oip_pkg::QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_pop && o_item_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == oip_pkg::QPTR_W'(oip_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == oip_pkg::QPTR_W'(oip_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cls;
        end
    end

endmodule

>>> rtl/oip_back.sv
// ----------------------------------------------------------------------------
// oip_back
// Runs the datagram grammar on classified bytes and registers the result.
// ----------------------------------------------------------------------------
module oip_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  oip_pkg::t_cls     i_item,
    output logic              o_pop,
    output logic              o_out_valid,
    output oip_pkg::t_result  o_result,
    input  logic              i_out_ready
);

    oip_pkg::t_phase                r_phase, n_phase;
    logic [31:0]                    r_acc, n_acc;
    logic                           r_seen, n_seen;
    logic                           r_lz, n_lz;
    logic                           r_hundred, n_hundred;
    logic [15:0]                    r_port, n_port;
    logic [oip_pkg::HEX_CNT_W-1:0]  r_hex_cnt, n_hex_cnt;
    logic [127:0]                   r_digest, n_digest;
    logic                           r_failed, n_failed;
    logic                           r_out_valid, n_out_valid;
    oip_pkg::t_result               r_result, n_result;
    logic [35:0]                    w_next;
    logic                           w_over;
    logic                           w_ok;
    logic [oip_pkg::HEX_CNT_W-1:0]  w_cnt_inc;

    // a non-final byte never needs the output slot
    assign o_pop = i_item_valid && (!i_item.last || !r_out_valid || i_out_ready);

    // decimal step: acc * 10 + digit
    assign w_next = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {32'b0, i_item.nibble};
    assign w_over = (r_phase == oip_pkg::PH_SIZE) ? (w_next[35:32] != '0)
                                                   : (w_next[35:16] != '0);
    assign w_cnt_inc = r_hex_cnt + 1'b1;

    // grammar step
    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_seen    = r_seen;
        n_lz      = r_lz;
        n_hundred = r_hundred;
        n_port    = r_port;
        n_hex_cnt = r_hex_cnt;
        n_digest  = r_digest;
        n_failed  = r_failed;
        n_result  = r_result;
        n_out_valid = r_out_valid && !i_out_ready;
        w_ok      = 1'b0;
        if (o_pop && !r_failed) begin
            unique case (r_phase) inside
                oip_pkg::PH_COMMAND, oip_pkg::PH_PORT, oip_pkg::PH_SIZE: begin
                    if (i_item.is_digit) begin
                        if ((r_seen && r_lz) || w_over) begin
                            n_failed = 1'b1;
                        end else begin
                            if (!r_seen) begin
                                n_lz = (i_item.nibble == 4'd0);
                            end
                            n_seen = 1'b1;
                            n_acc  = w_next[31:0];
                        end
                    end else if (i_item.is_space) begin
                        if (!r_seen) begin
                            n_failed = 1'b1;
                        end else if (r_phase == oip_pkg::PH_COMMAND) begin
                            if (r_acc != '0 && r_acc != oip_pkg::CMD_HUNDRED) begin
                                n_failed = 1'b1;
                            end else begin
                                n_hundred = (r_acc == oip_pkg::CMD_HUNDRED);
                                n_acc     = '0;
                                n_phase   = oip_pkg::PH_PORT;
                                n_seen    = 1'b0;
                                n_lz      = 1'b0;
                            end
                        end else if (r_acc == '0) begin
                            n_failed = 1'b1;
                        end else if (r_phase == oip_pkg::PH_PORT) begin
                            n_port  = r_acc[15:0];
                            n_acc   = '0;
                            n_phase = oip_pkg::PH_SIZE;
                            n_seen  = 1'b0;
                            n_lz    = 1'b0;
                        end else begin
                            // size is kept in the accumulator
                            n_phase = oip_pkg::PH_DIGEST;
                            n_seen  = 1'b0;
                            n_lz    = 1'b0;
                        end
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                oip_pkg::PH_DIGEST: begin
                    if (i_item.is_hex) begin
                        n_digest  = {r_digest[123:0], i_item.nibble};
                        n_hex_cnt = w_cnt_inc;
                        if (w_cnt_inc >= oip_pkg::HEX_CNT_W'(oip_pkg::DIGEST_HEX_DIGITS)) begin
                            n_phase = oip_pkg::PH_DONE;
                        end
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                oip_pkg::PH_DONE: begin
                    if (i_item.is_lf) begin
                        n_phase = oip_pkg::PH_LF;
                    end else if (i_item.is_cr) begin
                        n_phase = oip_pkg::PH_CR;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                oip_pkg::PH_CR: begin
                    if (i_item.is_lf) begin
                        n_phase = oip_pkg::PH_LF;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                default: begin
                    // anything after the line end fails
                    n_failed = 1'b1;
                end
            endcase
        end
        // final byte: publish the result and start over
        if (o_pop && i_item.last) begin
            w_ok = !n_failed && (n_phase == oip_pkg::PH_DONE || n_phase == oip_pkg::PH_LF);
            n_result.parse_ok     = w_ok;
            n_result.command_code = (w_ok && n_hundred) ? oip_pkg::CMD_CODE_HUNDRED : 7'd0;
            n_result.port_number  = w_ok ? n_port : 16'd0;
            n_result.image_bytes  = w_ok ? n_acc : 32'd0;
            n_result.digest_high  = w_ok ? n_digest[127:64] : 64'd0;
            n_result.digest_low   = w_ok ? n_digest[63:0] : 64'd0;
            n_out_valid = 1'b1;
            n_phase   = oip_pkg::PH_COMMAND;
            n_acc     = '0;
            n_seen    = 1'b0;
            n_lz      = 1'b0;
            n_hundred = 1'b0;
            n_port    = '0;
            n_hex_cnt = '0;
            n_digest  = '0;
            n_failed  = 1'b0;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= oip_pkg::PH_COMMAND;
            r_acc       <= '0;
            r_seen      <= 1'b0;
            r_lz        <= 1'b0;
            r_hundred   <= 1'b0;
            r_port      <= '0;
            r_hex_cnt   <= '0;
            r_digest    <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_seen      <= n_seen;
            r_lz        <= n_lz;
            r_hundred   <= n_hundred;
            r_port      <= n_port;
            r_hex_cnt   <= n_hex_cnt;
            r_digest    <= n_digest;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

>>> rtl/ota_invitation_parser.sv
// ----------------------------------------------------------------------------
// ota_invitation_parser
// Parses an update-invitation datagram received one byte per request.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while a stalled result has not filled the queue.
// A final byte passes two register stages (queue write, then parser step into
// the output register) before its result is valid.
// A 4-entry queue lets the byte side keep going while a result is stalled.
// Reset: synchronous active-low, clears queue, parse state and output valid.
module ota_invitation_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [7:0] rx_byte
    input  logic [7:0]   i_s_axis_tdata,
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [6:0] command_code, [22:7] port_number, [54:23] image_bytes,
    // [118:55] digest_high, [182:119] digest_low, [183] zero
    output logic [183:0] o_m_axis_tdata,
    // [0] parse_ok
    output logic         o_m_axis_tuser
);

    logic              w_item_valid;
    oip_pkg::t_cls     w_item;
    logic              w_pop;
    oip_pkg::t_result  w_result;

    oip_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .i_byte       (i_s_axis_tdata),
        .i_last       (i_s_axis_tlast),
        .o_ready      (o_s_axis_tready),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    oip_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_out_valid  (o_m_axis_tvalid),
        .o_result     (w_result),
        .i_out_ready  (i_m_axis_tready)
    );

    // result packing
    assign o_m_axis_tdata = {1'b0, w_result.digest_low, w_result.digest_high,
                             w_result.image_bytes, w_result.port_number,
                             w_result.command_code};
    assign o_m_axis_tuser = w_result.parse_ok;

endmodule

>>> rtl/oip_checker.sv
// ----------------------------------------------------------------------------
// oip_checker
// Port-level checks on the parser result stream, bound to the top level.
// ----------------------------------------------------------------------------
module oip_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [183:0] o_m_axis_tdata,
    input  logic         o_m_axis_tuser
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // failed parse carries all-zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("failed result has nonzero fields");

    // good parse has a legal command and nonzero port and size
    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            (o_m_axis_tdata[6:0] == 7'd0 || o_m_axis_tdata[6:0] == 7'd100) &&
            o_m_axis_tdata[22:7] != '0 && o_m_axis_tdata[54:23] != '0)
        else $error("good result with illegal fields");

endmodule

bind ota_invitation_parser oip_checker u_oip_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> tb/ota_invitation_parser_tb.sv
// ----------------------------------------------------------------------------
// ota_invitation_parser_tb
// Self-checking bench for the update-invitation datagram parser. Datagrams go
// in byte by byte on the slave stream; a scoreboard parses every accepted
// byte on its own and queues the result due on each final byte, and each
// result taken from the master stream is checked field by field against the
// oldest one queued. Directed datagrams cover field extremes, rejected
// numbers, bad digest lengths and endings; random datagrams are mostly well
// formed with random content, the rest flawed or plain noise. Both sides
// idle at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module ota_invitation_parser_tb;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int unsigned STAGE_BYTES = 40;

    // line endings and trailers after the digest
    typedef enum int {
        TAIL_NONE,
        TAIL_LF,
        TAIL_CRLF,
        TAIL_CR,
        TAIL_LF_LF,
        TAIL_LF_JUNK,
        TAIL_CR_CR,
        TAIL_SPACE
    } t_tail;

    // ways a random datagram is broken
    typedef enum int {
        FLAW_COMMAND,
        FLAW_PORT,
        FLAW_SIZE,
        FLAW_DIGEST_LEN,
        FLAW_TAIL,
        FLAW_TRUNCATE,
        FLAW_CORRUPT,
        FLAW_INSERT,
        FLAW_NOISE
    } t_flaw;

    // independent parser that predicts one result per datagram
    class invitation_scoreboard;
        oip_pkg::t_phase  phase;
        logic [31:0]      number;
        bit               digit_seen;
        bit               lead_zero;
        bit               cmd_hundred;
        bit               broken;
        logic [15:0]      port;
        logic [5:0]       nibbles;
        logic [63:0]      digest_hi;
        logic [63:0]      digest_lo;
        oip_pkg::t_result awaited[$];
        int unsigned      mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            phase       = oip_pkg::PH_COMMAND;
            number      = '0;
            digit_seen  = 1'b0;
            lead_zero   = 1'b0;
            cmd_hundred = 1'b0;
            broken      = 1'b0;
            port        = '0;
            nibbles     = '0;
            digest_hi   = '0;
            digest_lo   = '0;
        endfunction

        // close a decimal field at its space
        function bit end_number();
            if (!digit_seen) return 1'b0;
            case (phase)
                oip_pkg::PH_COMMAND: begin
                    if (number != 32'd0 && number != oip_pkg::CMD_HUNDRED) return 1'b0;
                    cmd_hundred = (number == oip_pkg::CMD_HUNDRED);
                    number = '0;
                    phase = oip_pkg::PH_PORT;
                end
                oip_pkg::PH_PORT: begin
                    if (number == 32'd0) return 1'b0;
                    port = number[15:0];
                    number = '0;
                    phase = oip_pkg::PH_SIZE;
                end
                default: begin
                    if (number == 32'd0) return 1'b0;
                    phase = oip_pkg::PH_DIGEST;
                end
            endcase
            digit_seen = 1'b0;
            lead_zero = 1'b0;
            return 1'b1;
        endfunction

        // advance the parse by one byte, 0 when the byte is not allowed here
        function bit absorb(logic [7:0] b);
            logic [63:0] next_val;
            logic [63:0] limit;
            logic [7:0]  nib;
            bit          hex;
            hex = 1'b1;
            nib = '0;
            if (phase == oip_pkg::PH_COMMAND || phase == oip_pkg::PH_PORT ||
                phase == oip_pkg::PH_SIZE) begin
                if (b >= oip_pkg::CH_ZERO && b <= oip_pkg::CH_NINE) begin
                    limit = (phase == oip_pkg::PH_SIZE) ? 64'hFFFF_FFFF : 64'hFFFF;
                    next_val = {32'd0, number} * 64'd10 + {56'd0, b - oip_pkg::CH_ZERO};
                    if (digit_seen && lead_zero) return 1'b0;
                    if (next_val > limit) return 1'b0;
                    if (!digit_seen) lead_zero = (b == oip_pkg::CH_ZERO);
                    digit_seen = 1'b1;
                    number = next_val[31:0];
                    return 1'b1;
                end
                if (b == oip_pkg::CH_SPACE) return end_number();
                return 1'b0;
            end
            case (phase)
                oip_pkg::PH_DIGEST: begin
                    if (b >= oip_pkg::CH_ZERO && b <= oip_pkg::CH_NINE)
                        nib = b - oip_pkg::CH_ZERO;
                    else if (b >= oip_pkg::CH_LA && b <= oip_pkg::CH_LF_HEX)
                        nib = b - oip_pkg::CH_LA + 8'd10;
                    else if (b >= oip_pkg::CH_UA && b <= oip_pkg::CH_UF)
                        nib = b - oip_pkg::CH_UA + 8'd10;
                    else hex = 1'b0;
                    if (!hex) return 1'b0;
                    digest_hi = {digest_hi[59:0], digest_lo[63:60]};
                    digest_lo = {digest_lo[59:0], nib[3:0]};
                    nibbles = nibbles + 6'd1;
                    if (nibbles >= oip_pkg::DIGEST_HEX_DIGITS) phase = oip_pkg::PH_DONE;
                    return 1'b1;
                end
                oip_pkg::PH_DONE: begin
                    if (b == oip_pkg::CH_LF) begin
                        phase = oip_pkg::PH_LF;
                        return 1'b1;
                    end
                    if (b == oip_pkg::CH_CR) begin
                        phase = oip_pkg::PH_CR;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                oip_pkg::PH_CR: begin
                    if (b == oip_pkg::CH_LF) begin
                        phase = oip_pkg::PH_LF;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                default: return 1'b0;
            endcase
        endfunction

        // accepted byte request; the final byte queues its result
        function void note_byte(logic [7:0] b, bit last);
            oip_pkg::t_result r;
            bit               ok;
            if (!broken) begin
                if (!absorb(b)) broken = 1'b1;
            end
            if (!last) return;
            ok = !broken && (phase == oip_pkg::PH_DONE || phase == oip_pkg::PH_LF);
            r = '0;
            r.parse_ok = ok;
            if (ok) begin
                r.command_code = cmd_hundred ? oip_pkg::CMD_CODE_HUNDRED : 7'd0;
                r.port_number  = port;
                r.image_bytes  = number;
                r.digest_high  = digest_hi;
                r.digest_low   = digest_lo;
            end
            awaited.push_back(r);
            restart();
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        // accepted result request against the oldest prediction
        function void check_result(logic [183:0] data, logic ok_bit);
            oip_pkg::t_result want;
            if (awaited.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none actual tuser %b tdata %h",
                         $time, ok_bit, data);
                return;
            end
            want = awaited.pop_front();
            compare("parse_ok", 64'(want.parse_ok), 64'(ok_bit));
            compare("command_code", 64'(want.command_code), 64'(data[6:0]));
            compare("port_number", 64'(want.port_number), 64'(data[22:7]));
            compare("image_bytes", 64'(want.image_bytes), 64'(data[54:23]));
            compare("digest_high", want.digest_high, data[118:55]);
            compare("digest_low", want.digest_low, data[182:119]);
            compare("pad", 64'd0, 64'(data[183]));
        endfunction

        function int expected_left();
            return awaited.size();
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         byte_valid = 1'b0;
    logic         byte_ready;
    logic [7:0]   byte_data = '0;
    logic         byte_last = 1'b0;
    logic         res_valid;
    logic         res_ready = 1'b0;
    logic [183:0] res_data;
    logic         res_ok;

    invitation_scoreboard sb;
    logic [7:0]  frame[$];
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    bit          stall_go = 1'b0;
    int          stall_left = 0;
    int unsigned bytes_sent = 0;
    int          quiet = 0;

    ota_invitation_parser i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (byte_valid),
        .o_s_axis_tready (byte_ready),
        .i_s_axis_tdata  (byte_data),
        .i_s_axis_tlast  (byte_last),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tuser  (res_ok)
    );

    always #10 clk = ~clk;

    // result side: check accepted results, idle at random or hold off
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready) sb.check_result(res_data, res_ok);
            if (stall_go) begin
                stall_left = HOLD_OFF_CYCLES;
                stall_go = 1'b0;
            end
            if (stall_left > 0) begin
                res_ready <= 1'b0;
                stall_left--;
            end else begin
                res_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    initial begin
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((byte_valid && byte_ready) || (res_valid && res_ready)) quiet = 0;
            else quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void push_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) frame.push_back(s[i]);
    endfunction

    function automatic void push_fill(string c);
        repeat (oip_pkg::DIGEST_HEX_DIGITS) push_text(c);
    endfunction

    // random hex digits in random case
    function automatic void push_hex(int n);
        int unsigned v;
        repeat (n) begin
            v = $urandom_range(15);
            if (v < 10) frame.push_back(8'(oip_pkg::CH_ZERO + v));
            else if ($urandom_range(1)) frame.push_back(8'(oip_pkg::CH_LA + v - 10));
            else frame.push_back(8'(oip_pkg::CH_UA + v - 10));
        end
    endfunction

    function automatic void push_tail(t_tail t);
        case (t)
            TAIL_LF:      frame.push_back(oip_pkg::CH_LF);
            TAIL_CRLF:    begin
                frame.push_back(oip_pkg::CH_CR);
                frame.push_back(oip_pkg::CH_LF);
            end
            TAIL_CR:      frame.push_back(oip_pkg::CH_CR);
            TAIL_LF_LF:   begin
                frame.push_back(oip_pkg::CH_LF);
                frame.push_back(oip_pkg::CH_LF);
            end
            TAIL_LF_JUNK: begin
                frame.push_back(oip_pkg::CH_LF);
                frame.push_back(8'($urandom_range(255)));
            end
            TAIL_CR_CR:   begin
                frame.push_back(oip_pkg::CH_CR);
                frame.push_back(oip_pkg::CH_CR);
            end
            TAIL_SPACE:   frame.push_back(oip_pkg::CH_SPACE);
            default:      ;
        endcase
    endfunction

    function automatic void push_invitation(string cmd, string port, string size,
                                            int ndig, t_tail t);
        push_text({cmd, " ", port, " ", size, " "});
        push_hex(ndig);
        push_tail(t);
    endfunction

    // mostly well formed datagrams, the rest with one flaw
    function automatic void build_random_invitation();
        string           cmd_s, port_s, size_s;
        longint unsigned port_v, size_v;
        int              ndig, pos;
        t_tail           tail;
        t_flaw           flaw;
        bit              flawed;
        flawed = ($urandom_range(99) < 30);
        flaw = t_flaw'($urandom_range(FLAW_NOISE));
        cmd_s = $urandom_range(1) ? "100" : "0";
        case ($urandom_range(3))
            0:       port_v = 1;
            1:       port_v = 65535;
            2:       port_v = 64'($urandom_range(99, 1));
            default: port_v = 64'($urandom_range(65535, 1));
        endcase
        case ($urandom_range(3))
            0:       size_v = 1;
            1:       size_v = 64'h0000_0000_FFFF_FFFF;
            2:       size_v = 64'($urandom_range(9999, 1));
            default: size_v = 64'($urandom);
        endcase
        if (size_v == 0) size_v = 1;
        port_s = $sformatf("%0d", port_v);
        size_s = $sformatf("%0d", size_v);
        ndig = oip_pkg::DIGEST_HEX_DIGITS;
        tail = t_tail'($urandom_range(TAIL_CRLF));
        if (flawed) begin
            case (flaw)
                FLAW_COMMAND: begin
                    case ($urandom_range(4))
                        0:       cmd_s = "101";
                        1:       cmd_s = "1";
                        2:       cmd_s = "65536";
                        3:       cmd_s = "0100";
                        default: cmd_s = "";
                    endcase
                end
                FLAW_PORT: begin
                    case ($urandom_range(3))
                        0:       port_s = "0";
                        1:       port_s = "65536";
                        2:       port_s = {"0", port_s};
                        default: port_s = "";
                    endcase
                end
                FLAW_SIZE: begin
                    case ($urandom_range(3))
                        0:       size_s = "0";
                        1:       size_s = "4294967296";
                        2:       size_s = {"0", size_s};
                        default: size_s = "99999999999";
                    endcase
                end
                FLAW_DIGEST_LEN: ndig = $urandom_range(1) ? oip_pkg::DIGEST_HEX_DIGITS - 1
                                                          : oip_pkg::DIGEST_HEX_DIGITS + 1;
                FLAW_TAIL: tail = t_tail'($urandom_range(TAIL_SPACE, TAIL_CR));
                default: ;
            endcase
        end
        push_invitation(cmd_s, port_s, size_s, ndig, tail);
        if (flawed) begin
            case (flaw)
                FLAW_TRUNCATE: begin
                    pos = $urandom_range(frame.size() - 1, 1);
                    while (frame.size() > pos) void'(frame.pop_back());
                end
                FLAW_CORRUPT: frame[$urandom_range(frame.size() - 1)] = 8'($urandom_range(255));
                FLAW_INSERT: frame.insert($urandom_range(frame.size() - 1),
                                          8'($urandom_range(255)));
                FLAW_NOISE: begin
                    frame.delete();
                    repeat ($urandom_range(8, 1)) frame.push_back(8'($urandom_range(255)));
                end
                default: ;
            endcase
        end
    endfunction

    // offer the bytes of one datagram, tlast on the final one
    task automatic send_frame();
        int  i;
        bit  last;
        for (i = 0; i < frame.size(); i++) begin
            last = (i == frame.size() - 1);
            while ($urandom_range(99) < src_idle_pct) begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
            byte_valid <= 1'b1;
            byte_data <= frame[i];
            byte_last <= last;
            @(posedge clk);
            while (!byte_ready) @(posedge clk);
            sb.note_byte(frame[i], last);
            bytes_sent++;
        end
        frame.delete();
    endtask

    task automatic wait_drained();
        byte_valid <= 1'b0;
        while (sb.expected_left() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    int src_plan[3]  = '{28, 74, 0};
    int sink_plan[3] = '{74, 28, 0};

    initial begin
        int          stage;
        int unsigned start_bytes;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        src_idle_pct = src_plan[0];
        sink_idle_pct = sink_plan[0];

        // field extremes and every valid ending
        push_text("0 1 1 ");
        push_fill("0");
        send_frame();
        push_text("100 65535 4294967295 ");
        push_fill("F");
        push_tail(TAIL_LF);
        send_frame();
        push_text("100 80 1024 0123456789abcdefABCDEF0123456789");
        push_tail(TAIL_CRLF);
        send_frame();
        push_text("0 9 4294967295 ");
        push_fill("f");
        send_frame();
        // rejected numbers
        push_invitation("101", "1", "1", oip_pkg::DIGEST_HEX_DIGITS, TAIL_NONE);
        send_frame();
        push_invitation("00", "1", "1", oip_pkg::DIGEST_HEX_DIGITS, TAIL_NONE);
        send_frame();
        push_invitation("0", "0", "1", oip_pkg::DIGEST_HEX_DIGITS, TAIL_NONE);
        send_frame();
        push_invitation("0", "65536", "1", oip_pkg::DIGEST_HEX_DIGITS, TAIL_LF);
        send_frame();
        push_invitation("100", "01", "1", oip_pkg::DIGEST_HEX_DIGITS, TAIL_NONE);
        send_frame();
        push_invitation("0", "1", "0", oip_pkg::DIGEST_HEX_DIGITS, TAIL_NONE);
        send_frame();
        push_invitation("0", "1", "4294967296", oip_pkg::DIGEST_HEX_DIGITS, TAIL_NONE);
        send_frame();
        push_invitation("0", "", "1", oip_pkg::DIGEST_HEX_DIGITS, TAIL_NONE);
        send_frame();
        // digest length, bad digit and broken endings
        push_invitation("0", "1", "1", oip_pkg::DIGEST_HEX_DIGITS - 1, TAIL_NONE);
        send_frame();
        push_invitation("0", "1", "1", oip_pkg::DIGEST_HEX_DIGITS + 1, TAIL_NONE);
        send_frame();
        push_text("0 1 1 g");
        send_frame();
        push_invitation("0", "1", "1", oip_pkg::DIGEST_HEX_DIGITS, TAIL_CR);
        send_frame();
        push_invitation("100", "2", "3", oip_pkg::DIGEST_HEX_DIGITS, TAIL_LF_JUNK);
        send_frame();
        push_invitation("100", "7", "7", oip_pkg::DIGEST_HEX_DIGITS, TAIL_CR_CR);
        send_frame();
        // final byte inside the port or the size number
        push_text("0 12");
        send_frame();
        push_text("0 1 1");
        send_frame();
        // single byte datagrams, nul and all ones
        frame.push_back(8'h00);
        send_frame();
        frame.push_back(8'hFF);
        send_frame();

        // long receiver hold-off while short datagrams keep coming
        stall_go = 1'b1;
        repeat (24) begin
            repeat ($urandom_range(3, 1)) frame.push_back(8'($urandom_range(255)));
            send_frame();
        end
        wait_drained();

        // random datagrams under each idle setting
        for (stage = 0; stage < 3; stage++) begin
            src_idle_pct = src_plan[stage];
            sink_idle_pct = sink_plan[stage];
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < STAGE_BYTES) begin
                build_random_invitation();
                send_frame();
            end
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.expected_left() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/oip_pkg.sv
rtl/oip_front.sv
rtl/oip_back.sv
rtl/ota_invitation_parser.sv
rtl/oip_checker.sv
tb/ota_invitation_parser_tb.sv
